FILE: hw/rtl/dsmr_telegram_framer_macros.svh
// Assertion helpers shared by the framer RTL.
`ifndef DSMR_TELEGRAM_FRAMER_MACROS_SVH
`define DSMR_TELEGRAM_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSMR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dsmr_frm_pkg.sv
`default_nettype none

package dsmr_frm_pkg;

  localparam int unsigned BUF_DEPTH = 2048;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned FLEN_W = 17;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CFG_W  = 16;

  localparam logic [FLEN_W-1:0] BUF_LIMIT = FLEN_W'(BUF_DEPTH);

  typedef enum logic [EV_W-1:0] {
    EV_IGNORED  = 3'd0,
    EV_STORED   = 3'd1,
    EV_DONE     = 3'd2,
    EV_OVERFLOW = 3'd3,
    EV_TIMEOUT  = 3'd4
  } event_e;

  typedef enum logic [IDX_W-1:0] {
    REG_ENCRYPTED_MODE  = 2'd0,
    REG_MAX_LENGTH      = 2'd1,
    REG_RECEIVE_TIMEOUT = 2'd2
  } reg_idx_e;

  localparam logic REQ_TICK = 1'b1;

  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_EXCL   = 8'h21;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_START  = 8'hDB;

  localparam logic [FLEN_W-1:0] LEN_HDR        = 17'd13;
  localparam logic [CNT_W-1:0]  LEN_KNOWN_FROM = 12'd20;
  localparam logic [CNT_W-1:0]  LEN_HI_POS     = 12'd11;
  localparam logic [CNT_W-1:0]  LEN_LO_POS     = 12'd12;

  localparam logic [CNT_W-1:0] MAX_LENGTH_RST = 12'd1500;
  localparam logic [TMO_W-1:0] TIMEOUT_RST    = 16'd200;

  typedef struct packed {
    logic             encrypted_mode;
    logic [CNT_W-1:0] max_length;
    logic [TMO_W-1:0] receive_timeout;
  } cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [BYTE_W-1:0] rx_byte;
  } req_t;

  typedef struct packed {
    event_e            event_res;
    logic              store_valid;
    logic [ADDR_W-1:0] store_addr;
    logic [BYTE_W-1:0] store_byte;
    logic [CNT_W-1:0]  telegram_length;
  } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsmr_frm_if.sv
`default_nettype none

interface dsmr_frm_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [dsmr_frm_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface dsmr_frm_res_if;
  logic                             valid;
  logic                             ready;
  logic [dsmr_frm_pkg::EV_W-1:0]    event_res;
  logic                             store_valid;
  logic [dsmr_frm_pkg::ADDR_W-1:0]  store_addr;
  logic [dsmr_frm_pkg::BYTE_W-1:0]  store_byte;
  logic [dsmr_frm_pkg::CNT_W-1:0]   telegram_length;

  modport source (output valid, event_res, store_valid, store_addr, store_byte,
                  telegram_length, input ready);
  modport sink   (input valid, event_res, store_valid, store_addr, store_byte,
                  telegram_length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dsmr_frm_cfg.sv
`default_nettype none

module dsmr_frm_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [dsmr_frm_pkg::IDX_W-1:0]  idx_i,
  input  wire logic [dsmr_frm_pkg::CFG_W-1:0]  wdata_i,
  output dsmr_frm_pkg::cfg_t                   cfg_o
);

  dsmr_frm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (dsmr_frm_pkg::reg_idx_e'(idx_i))
        dsmr_frm_pkg::REG_ENCRYPTED_MODE:  cfg_d.encrypted_mode  = wdata_i[0];
        dsmr_frm_pkg::REG_MAX_LENGTH:
          cfg_d.max_length = wdata_i[dsmr_frm_pkg::CNT_W-1:0];
        dsmr_frm_pkg::REG_RECEIVE_TIMEOUT:
          cfg_d.receive_timeout = wdata_i[dsmr_frm_pkg::TMO_W-1:0];
        default: cfg_d = cfg_q;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encrypted_mode  <= 1'b0;
      cfg_q.max_length      <= dsmr_frm_pkg::MAX_LENGTH_RST;
      cfg_q.receive_timeout <= dsmr_frm_pkg::TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dsmr_frm_in_reg.sv
`default_nettype none

module dsmr_frm_in_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  dsmr_frm_req_if.sink        req_i,
  input  wire logic           room_i,
  output dsmr_frm_pkg::req_t  req_o,
  output logic                step_o
);

  logic               vld_q, vld_d;
  logic               accept;
  dsmr_frm_pkg::req_t req_q;

  assign step_o      = vld_q & room_i;
  assign req_i.ready = ~vld_q | room_i;
  assign accept      = req_i.valid & req_i.ready;
  assign vld_d       = accept | (vld_q & ~room_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // hold the item until the engine takes it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.req_type <= req_i.req_type;
      req_q.rx_byte  <= req_i.rx_byte;
    end
  end

  assign req_o = req_q;

endmodule

`default_nettype wire

FILE: hw/rtl/dsmr_frm_engine.sv
`default_nettype none

module dsmr_frm_engine #(
  parameter int unsigned BUF_DEPTH = dsmr_frm_pkg::BUF_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dsmr_frm_pkg::cfg_t  cfg_i,
  input  wire logic                step_i,
  input  wire dsmr_frm_pkg::req_t  req_i,
  output dsmr_frm_pkg::res_t       res_o
);

  localparam int unsigned CW = dsmr_frm_pkg::CNT_W;
  localparam int unsigned FW = dsmr_frm_pkg::FLEN_W;
  localparam int unsigned TW = dsmr_frm_pkg::TMO_W;
  localparam int unsigned BW = dsmr_frm_pkg::BYTE_W;
  localparam int unsigned AW = dsmr_frm_pkg::ADDR_W;

  localparam logic [FW-1:0] BUF_LIMIT = FW'(BUF_DEPTH);

  logic          in_q, in_d, foot_q, foot_d;
  logic [CW-1:0] cnt_q, cnt_d, brk_q, brk_d;
  logic [BW-1:0] lhi_q, lhi_d, llo_q, llo_d;
  logic [FW-1:0] flen_q, flen_d;
  logic [TW-1:0] idle_q, idle_d;

  logic          start, in_e, foot_e;
  logic [CW-1:0] cnt_e, brk_e, rew, base, cnt_n;
  logic [BW-1:0] lhi_e, llo_e, lhi_n, llo_n, c;
  logic [FW-1:0] flen_e, flen_n, limit, max_ext;
  logic [TW-1:0] idle_inc;
  logic          is_break;

  dsmr_frm_pkg::res_t res;

  assign c        = req_i.rx_byte;
  assign is_break = (c == dsmr_frm_pkg::CH_LF) || (c == dsmr_frm_pkg::CH_CR);
  assign max_ext  = FW'(cfg_i.max_length);
  assign limit    = (max_ext < BUF_LIMIT) ? max_ext : BUF_LIMIT;
  assign idle_inc = (idle_q != '1) ? idle_q + TW'(1) : idle_q;

  // a start byte restarts the frame before anything else looks at it (in encrypted mode only outside a frame)
  assign start  = cfg_i.encrypted_mode ? (~in_q && (c == dsmr_frm_pkg::CH_START))
                                       : (c == dsmr_frm_pkg::CH_SLASH);
  assign in_e   = in_q | start;
  assign foot_e = start ? 1'b0 : foot_q;
  assign cnt_e  = start ? '0 : cnt_q;
  assign brk_e  = start ? '0 : brk_q;
  assign lhi_e  = start ? '0 : lhi_q;
  assign llo_e  = start ? '0 : llo_q;
  assign flen_e = start ? '0 : flen_q;

  // plain mode: rewind over line breaks that sit directly before '('
  assign rew   = (c == dsmr_frm_pkg::CH_LPAREN) ? ((brk_e <= cnt_e) ? brk_e : cnt_e) : '0;
  assign base  = cnt_e - rew;

  // encrypted mode: capture the length bytes
  assign lhi_n  = (cnt_e == dsmr_frm_pkg::LEN_HI_POS) ? c : lhi_e;
  assign llo_n  = (cnt_e == dsmr_frm_pkg::LEN_LO_POS) ? c : llo_e;

  always_comb begin
    in_d   = in_q;
    foot_d = foot_q;
    cnt_d  = cnt_q;
    brk_d  = brk_q;
    lhi_d  = lhi_q;
    llo_d  = llo_q;
    flen_d = flen_q;
    idle_d = idle_q;
    cnt_n  = '0;
    flen_n = '0;

    res.event_res       = dsmr_frm_pkg::EV_IGNORED;
    res.store_valid     = 1'b0;
    res.store_addr      = '0;
    res.store_byte      = '0;
    res.telegram_length = cnt_q;

    if (req_i.req_type == dsmr_frm_pkg::REQ_TICK) begin
      if (in_q) begin
        if (idle_inc > cfg_i.receive_timeout) begin
          in_d = 1'b0; foot_d = 1'b0; cnt_d = '0; brk_d = '0;
          lhi_d = '0; llo_d = '0; flen_d = '0; idle_d = '0;
          res.event_res       = dsmr_frm_pkg::EV_TIMEOUT;
          res.telegram_length = '0;
        end else begin
          idle_d = idle_inc;
        end
      end
    end else begin
      idle_d = '0;
      if (!in_e) begin
        res.event_res = dsmr_frm_pkg::EV_IGNORED;
      end else if (FW'(cnt_e) >= limit) begin
        in_d = 1'b0; foot_d = 1'b0; cnt_d = '0; brk_d = '0;
        lhi_d = '0; llo_d = '0; flen_d = '0;
        res.event_res       = dsmr_frm_pkg::EV_OVERFLOW;
        res.telegram_length = '0;
      end else if (!cfg_i.encrypted_mode) begin
        cnt_n = base + CW'(1);
        in_d   = 1'b1;
        foot_d = foot_e;
        cnt_d  = cnt_n;
        brk_d  = is_break ? brk_e + CW'(1) : '0;
        lhi_d  = lhi_e;
        llo_d  = llo_e;
        flen_d = flen_e;
        res.store_valid     = 1'b1;
        res.store_addr      = base[AW-1:0];
        res.store_byte      = c;
        res.telegram_length = cnt_n;
        res.event_res       = dsmr_frm_pkg::EV_STORED;
        if (c == dsmr_frm_pkg::CH_EXCL) begin
          foot_d = 1'b1;
        end else if (foot_e && (c == dsmr_frm_pkg::CH_LF)) begin
          res.event_res = dsmr_frm_pkg::EV_DONE;
          in_d = 1'b0; foot_d = 1'b0; cnt_d = '0; brk_d = '0;
          lhi_d = '0; llo_d = '0; flen_d = '0;
        end
      end else begin
        cnt_n  = cnt_e + CW'(1);
        flen_n = ((flen_e == '0) && (cnt_n > dsmr_frm_pkg::LEN_KNOWN_FROM))
                 ? dsmr_frm_pkg::LEN_HDR + FW'({lhi_n, llo_n}) : flen_e;
        in_d   = 1'b1;
        foot_d = foot_e;
        cnt_d  = cnt_n;
        brk_d  = brk_e;
        lhi_d  = lhi_n;
        llo_d  = llo_n;
        flen_d = flen_n;
        res.store_valid     = 1'b1;
        res.store_addr      = cnt_e[AW-1:0];
        res.store_byte      = c;
        res.telegram_length = cnt_n;
        res.event_res       = dsmr_frm_pkg::EV_STORED;
        if ((flen_n != '0) && (FW'(cnt_n) == flen_n)) begin
          res.event_res = dsmr_frm_pkg::EV_DONE;
          in_d = 1'b0; foot_d = 1'b0; cnt_d = '0; brk_d = '0;
          lhi_d = '0; llo_d = '0; flen_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q   <= 1'b0;
      foot_q <= 1'b0;
      cnt_q  <= '0;
      brk_q  <= '0;
      lhi_q  <= '0;
      llo_q  <= '0;
      flen_q <= '0;
      idle_q <= '0;
    end else if (step_i) begin
      in_q   <= in_d;
      foot_q <= foot_d;
      cnt_q  <= cnt_d;
      brk_q  <= brk_d;
      lhi_q  <= lhi_d;
      llo_q  <= llo_d;
      flen_q <= flen_d;
      idle_q <= idle_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

FILE: hw/rtl/dsmr_frm_out_reg.sv
`default_nettype none

module dsmr_frm_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire dsmr_frm_pkg::res_t  res_i,
  dsmr_frm_res_if.source           res_o,
  output logic                     room_o
);

  logic               vld_q, vld_d;
  dsmr_frm_pkg::res_t res_q;

  assign room_o = ~vld_q | res_o.ready;
  assign vld_d  = step_i | (vld_q & ~res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid           = vld_q;
  assign res_o.event_res       = res_q.event_res;
  assign res_o.store_valid     = res_q.store_valid;
  assign res_o.store_addr      = res_q.store_addr;
  assign res_o.store_byte      = res_q.store_byte;
  assign res_o.telegram_length = res_q.telegram_length;

endmodule

`default_nettype wire

FILE: hw/rtl/dsmr_telegram_framer.sv
// Channel   Dir  Handshake      Carries
// req_i     in   valid / ready  req_type, rx_byte
// res_o     out  valid / ready  event_res, store_valid, store_addr, store_byte,
//                               telegram_length
//
// One item per cycle sustained while results are taken; a result passes through the input
// register and then the result register, with the frame-state update combinational between.
// Reset is asynchronous: frame state clears, configuration and valid flags return to their defaults.
// A stalled result holds in the output register; the input register then fills and
// ready drops until the result is taken.
`default_nettype none
`include "dsmr_telegram_framer_macros.svh"

module dsmr_telegram_framer #(
  parameter int unsigned BUF_DEPTH = dsmr_frm_pkg::BUF_DEPTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dsmr_frm_pkg::IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dsmr_frm_pkg::CFG_W-1:0]  cfg_wdata_i,
  dsmr_frm_req_if.sink                         req_i,
  dsmr_frm_res_if.source                       res_o
);

  dsmr_frm_pkg::cfg_t cfg;
  dsmr_frm_pkg::req_t req;
  dsmr_frm_pkg::res_t res;
  logic               step;
  logic               room;
  logic               store_ev;
  logic               store_ok;
  logic               abort_out;
  logic               len_zero;

  dsmr_frm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  dsmr_frm_in_reg u_in_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .room_i (room),
    .req_o  (req),
    .step_o (step)
  );

  dsmr_frm_engine #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .req_i  (req),
    .res_o  (res)
  );

  dsmr_frm_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_i  (res),
    .res_o  (res_o),
    .room_o (room)
  );

  assign store_ev  = (res_o.event_res == dsmr_frm_pkg::EV_STORED) ||
                     (res_o.event_res == dsmr_frm_pkg::EV_DONE);
  assign store_ok  = (res_o.store_valid == store_ev);
  assign abort_out = res_o.valid && ((res_o.event_res == dsmr_frm_pkg::EV_OVERFLOW) ||
                                     (res_o.event_res == dsmr_frm_pkg::EV_TIMEOUT));
  assign len_zero  = (res_o.telegram_length == '0);

  `DSMR_ASSERT_NEXT(a_step_res, clk_i, rst_ni, step, res_o.valid, "item advanced but no result")
  `DSMR_ASSERT_NOW(a_store_ev, clk_i, rst_ni, res_o.valid, store_ok, "store flag disagrees with event")
  `DSMR_ASSERT_NOW(a_abort_len, clk_i, rst_ni, abort_out, len_zero, "abort with non-zero length")

endmodule

`default_nettype wire
